// ===== rtl/b64d_pkg.sv =====
// shared types and constants of the base64 stream decoder
package b64d_pkg;

  // widths of the beat fields
  localparam int CHAR_W   = 8;
  localparam int BYTE_W   = 8;
  localparam int SEXTET_W = 6;
  localparam int ACC_W    = 3 * SEXTET_W;
  localparam int QUAD_W   = 24;

  // most results that one input beat can cause
  localparam int MAX_RES = 3;

  // result queue geometry
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int NUM_W      = $clog2(MAX_RES + 1);

  // fill levels above which the input side holds off
  localparam logic [CNT_W-1:0] LIMIT_IDLE = CNT_W'(FIFO_DEPTH - MAX_RES);
  localparam logic [CNT_W-1:0] LIMIT_BUSY = CNT_W'(FIFO_DEPTH - 2 * MAX_RES);

  // alphabet offsets
  localparam logic [SEXTET_W-1:0] LOWER_BASE = 6'd26;
  localparam logic [SEXTET_W-1:0] DIGIT_BASE = 6'd52;
  localparam logic [SEXTET_W-1:0] PLUS_CODE  = 6'd62;
  localparam logic [SEXTET_W-1:0] SLASH_CODE = 6'd63;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_PAD  = 2'd2,
    ST_PARTIAL  = 2'd3
  } status_t;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_valid;
    status_t           status;
    logic              end_of_stream;
  } res_t;

  // everything one input beat produces
  typedef struct packed {
    logic [NUM_W-1:0]     num;
    res_t [MAX_RES-1:0]   res;
  } dec_out_t;

endpackage

// ===== rtl/base64_stream_decoder_unit.sv =====
// top level of the streaming base64 decoder
//
// usage:
//   input channel: one encoded character per beat on in_char_in, in_last_char
//   high on the final character of a stream. whitespace is skipped, other
//   characters gather into quads of the standard alphabet.
//   result channel: one decoded byte per beat (out_data_byte, out_byte_valid),
//   with out_status and out_end_of_stream. the last beat of each stream has
//   out_end_of_stream high and carries the final status; when that status is
//   not ok the consumer drops the bytes of the stream. a stream end with no
//   byte to give yields a beat with out_byte_valid low.
// path: a character is registered at acceptance, decoded in the next cycle
//   and its bytes enter the result queue at the following edge.
// throughput: one character per cycle unless stalled; a completed quad adds up
//   to three beats to a 16-entry result queue that drains one beat per cycle
//   unless stalled; the result port sets the rate (at most one byte per cycle).
// stall: out_stall holds the head beat and the queue fills; in_stall rises
//   above 10 queued beats with a character staged, above 13 with none staged
// reset: synchronous active-low rst_n empties the queue and clears the quad
//   and sticky status, so the first beat after reset starts a new stream.
module base64_stream_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [b64d_pkg::CHAR_W-1:0]   in_char_in,
  input  logic                          in_last_char,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [b64d_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                          out_byte_valid,
  output logic [1:0]                    out_status,
  output logic                          out_end_of_stream
);
  import b64d_pkg::*;

  // character staging register
  logic                stg_v_r;
  logic [CHAR_W-1:0]   stg_char_r;
  logic                stg_last_r;
  logic                in_acc;

  dec_out_t            dec_out;
  res_t                head;
  logic                not_empty;
  logic [CNT_W-1:0]    fill;
  logic                pop;

  // hold off input when the queue might not fit the staged beat plus a new one
  assign in_stall = stg_v_r ? (fill > LIMIT_BUSY) : (fill > LIMIT_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= in_acc;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_char_r <= in_char_in;
      stg_last_r <= in_last_char;
    end
  end

  b64d_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .stg_v    (stg_v_r),
    .stg_char (stg_char_r),
    .stg_last (stg_last_r),
    .dec_out  (dec_out)
  );

  assign pop = not_empty && !out_stall;

  b64d_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (dec_out),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (fill)
  );

  assign out_valid         = not_empty;
  assign out_data_byte     = head.data_byte;
  assign out_byte_valid    = head.byte_valid;
  assign out_status        = head.status;
  assign out_end_of_stream = head.end_of_stream;

`ifndef NO_ASSERTIONS
  // the staged beat always finds room in the queue
  a_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r |-> (fill <= CNT_W'(FIFO_DEPTH - MAX_RES)))
    else $error("staged beat without queue room");

  // an accepted character is decoded in the next cycle
  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> stg_v_r)
    else $error("accepted character not staged");

  // a non-final result never reports an error
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_stream) |-> (out_status == ST_OK && out_byte_valid))
    else $error("error reported before end of stream");
`endif

endmodule

// ===== rtl/b64d_decode.sv =====
// quad assembly, padding checks and sticky status for one character a cycle
module b64d_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          stg_v,
  input  logic [b64d_pkg::CHAR_W-1:0]   stg_char,
  input  logic                          stg_last,
  output b64d_pkg::dec_out_t            dec_out
);
  import b64d_pkg::*;

  logic [1:0]        qpos_r, qpos_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              tpad_r, tpad_nxt;
  status_t           sticky_r, sticky_nxt, sticky_fin;

  logic [SEXTET_W-1:0] sxt;
  logic                is_pad, is_skip, is_bad, last;
  logic [QUAD_W-1:0]   quad;
  logic [BYTE_W-1:0]   bytes [MAX_RES];
  logic [NUM_W-1:0]    nb;

  // character classes
  always_comb begin
    sxt     = '0;
    is_pad  = 1'b0;
    is_skip = 1'b0;
    is_bad  = 1'b0;
    if (stg_char >= 8'h41 && stg_char <= 8'h5a) begin
      sxt = SEXTET_W'(stg_char - 8'h41);
    end else if (stg_char >= 8'h61 && stg_char <= 8'h7a) begin
      sxt = SEXTET_W'(stg_char - 8'h61) + LOWER_BASE;
    end else if (stg_char >= 8'h30 && stg_char <= 8'h39) begin
      sxt = SEXTET_W'(stg_char - 8'h30) + DIGIT_BASE;
    end else if (stg_char == 8'h2b) begin
      sxt = PLUS_CODE;
    end else if (stg_char == 8'h2f) begin
      sxt = SLASH_CODE;
    end else if (stg_char == 8'h3d) begin
      is_pad = 1'b1;
    end else if (stg_char == 8'h20 || stg_char == 8'h09 ||
                 stg_char == 8'h0a || stg_char == 8'h0d) begin
      is_skip = 1'b1;
    end else begin
      is_bad = 1'b1;
    end
  end

  assign last = stg_v && stg_last;

  always_comb begin
    qpos_nxt   = qpos_r;
    acc_nxt    = acc_r;
    tpad_nxt   = tpad_r;
    sticky_nxt = sticky_r;
    quad       = '0;
    nb         = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      bytes[i] = '0;
    end
    if (stg_v && !is_skip && sticky_r == ST_OK) begin
      if (is_bad) begin
        sticky_nxt = ST_BAD_CHAR;
      end else if (is_pad) begin
        if (qpos_r < 2'd2) begin
          sticky_nxt = ST_BAD_PAD;
        end else if (qpos_r == 2'd2) begin
          tpad_nxt = 1'b1;
          acc_nxt  = {acc_r[ACC_W-SEXTET_W-1:0], {SEXTET_W{1'b0}}};
          qpos_nxt = 2'd3;
        end else begin
          quad     = {acc_r, {SEXTET_W{1'b0}}};
          bytes[0] = quad[23:16];
          bytes[1] = quad[15:8];
          nb       = tpad_r ? NUM_W'(1) : NUM_W'(2);
          qpos_nxt = '0;
          acc_nxt  = '0;
          tpad_nxt = 1'b0;
        end
      end else begin
        if (qpos_r == 2'd3 && tpad_r) begin
          sticky_nxt = ST_BAD_PAD;
        end else if (qpos_r < 2'd3) begin
          acc_nxt  = {acc_r[ACC_W-SEXTET_W-1:0], sxt};
          qpos_nxt = qpos_r + 2'd1;
        end else begin
          quad     = {acc_r, sxt};
          bytes[0] = quad[23:16];
          bytes[1] = quad[15:8];
          bytes[2] = quad[7:0];
          nb       = NUM_W'(3);
          qpos_nxt = '0;
          acc_nxt  = '0;
          tpad_nxt = 1'b0;
        end
      end
    end
  end

  // open quad at end of stream
  assign sticky_fin = (last && sticky_nxt == ST_OK && qpos_nxt != 2'd0) ? ST_PARTIAL
                                                                         : sticky_nxt;

  always_comb begin
    dec_out.num = (last && nb == '0) ? NUM_W'(1) : nb;
    for (int i = 0; i < MAX_RES; i++) begin
      dec_out.res[i].data_byte     = bytes[i];
      dec_out.res[i].byte_valid    = (NUM_W'(i) < nb);
      dec_out.res[i].status        = sticky_fin;
      dec_out.res[i].end_of_stream = last &&
        ((nb == '0 && i == 0) || (nb != '0 && NUM_W'(i) == nb - NUM_W'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpos_r   <= '0;
      acc_r    <= '0;
      tpad_r   <= 1'b0;
      sticky_r <= ST_OK;
    end else if (last) begin
      qpos_r   <= '0;
      acc_r    <= '0;
      tpad_r   <= 1'b0;
      sticky_r <= ST_OK;
    end else begin
      qpos_r   <= qpos_nxt;
      acc_r    <= acc_nxt;
      tpad_r   <= tpad_nxt;
      sticky_r <= sticky_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // end of stream leaves the decoder clean
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    last |=> (qpos_r == 2'd0 && sticky_r == ST_OK && !tpad_r))
    else $error("decoder state not cleared after end of stream");

  // once an error is latched no bytes come out
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v && sticky_r != ST_OK) |-> (nb == '0))
    else $error("bytes emitted after an error");

  // third-place pad only ever seen with the fourth place open
  a_tpad_pos: assert property (@(posedge clk) disable iff (!rst_n)
    tpad_r |-> (qpos_r == 2'd3))
    else $error("pad flag set outside the fourth place");

  // every stream end produces exactly one final beat
  a_last_num: assert property (@(posedge clk) disable iff (!rst_n)
    last |-> (dec_out.num != '0))
    else $error("end of stream without a result");
`endif

endmodule

// ===== rtl/b64d_res_fifo.sv =====
// result queue taking up to three beats a cycle and giving one
module b64d_res_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  b64d_pkg::dec_out_t           push,
  input  logic                         pop,
  output b64d_pkg::res_t               head,
  output logic                         not_empty,
  output logic [b64d_pkg::CNT_W-1:0]   count
);
  import b64d_pkg::*;

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;
  assign cnt_nxt   = cnt_r + CNT_W'(push.num) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (NUM_W'(i) < push.num) begin
        mem_r[wr_ptr_r + PTR_W'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.num);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(push.num) + cnt_r) <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty result queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != CNT_W'(FIFO_DEPTH)) |-> (PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(cnt_r)))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== test/b64d_stream_checker.sv =====
// decoded-byte predictor and result comparator for the base64 stream decoder
`timescale 1ns / 100ps

module b64d_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_last_char,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_data_byte,
  input  logic       out_byte_valid,
  input  logic [1:0] out_status,
  input  logic       out_end_of_stream,
  output int         mismatch_count,
  output int         beats_waiting,
  output int         beats_checked
);
  import b64d_pkg::*;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PAD,
    KIND_SPACE,
    KIND_BAD
  } char_kind_t;

  // decoder state as the stream sees it
  logic [1:0]  quad_fill    = '0;
  logic [17:0] sextet_acc   = '0;
  logic        pad_in_third = 1'b0;
  status_t     stream_status = ST_OK;

  res_t decoded_beats[$];

  task automatic decode_char(input logic [7:0] ch, input logic last);
    char_kind_t kind;
    logic [7:0] ofs;
    logic [5:0] sx;
    logic [23:0] word;
    logic [7:0] bytes_out[3];
    int nb;
    res_t beat;
    nb = 0;
    sx = '0;
    kind = KIND_DATA;
    if (ch >= "A" && ch <= "Z") begin
      ofs = ch - "A";
      sx = ofs[5:0];
    end else if (ch >= "a" && ch <= "z") begin
      ofs = ch - "a";
      sx = ofs[5:0] + LOWER_BASE;
    end else if (ch >= "0" && ch <= "9") begin
      ofs = ch - "0";
      sx = ofs[5:0] + DIGIT_BASE;
    end else if (ch == "+") begin
      sx = PLUS_CODE;
    end else if (ch == "/") begin
      sx = SLASH_CODE;
    end else if (ch == "=") begin
      kind = KIND_PAD;
    end else if (ch == " " || ch == "\t" || ch == "\n" || ch == "\r") begin
      kind = KIND_SPACE;
    end else begin
      kind = KIND_BAD;
    end

    if (kind != KIND_SPACE && stream_status == ST_OK) begin
      if (kind == KIND_BAD) begin
        stream_status = ST_BAD_CHAR;
      end else if (kind == KIND_PAD) begin
        if (quad_fill < 2) begin
          stream_status = ST_BAD_PAD;
        end else if (quad_fill == 2) begin
          pad_in_third = 1'b1;
          sextet_acc = {sextet_acc[11:0], 6'd0};
          quad_fill = 2'd3;
        end else begin
          word = {sextet_acc, 6'd0};
          bytes_out[nb] = word[23:16];
          nb++;
          if (!pad_in_third) begin
            bytes_out[nb] = word[15:8];
            nb++;
          end
          quad_fill = '0;
          sextet_acc = '0;
          pad_in_third = 1'b0;
        end
      end else if (quad_fill == 3 && pad_in_third) begin
        // sextet after a pad in the third place
        stream_status = ST_BAD_PAD;
      end else if (quad_fill < 3) begin
        sextet_acc = {sextet_acc[11:0], sx};
        quad_fill = quad_fill + 2'd1;
      end else begin
        word = {sextet_acc, sx};
        bytes_out[0] = word[23:16];
        bytes_out[1] = word[15:8];
        bytes_out[2] = word[7:0];
        nb = 3;
        quad_fill = '0;
        sextet_acc = '0;
        pad_in_third = 1'b0;
      end
    end

    if (last && stream_status == ST_OK && quad_fill != 0)
      stream_status = ST_PARTIAL;

    for (int i = 0; i < nb; i++) begin
      beat.data_byte = bytes_out[i];
      beat.byte_valid = 1'b1;
      beat.status = stream_status;
      beat.end_of_stream = last && (i == nb - 1);
      decoded_beats.insert(decoded_beats.size(), beat);
    end

    if (last) begin
      if (nb == 0) begin
        beat.data_byte = '0;
        beat.byte_valid = 1'b0;
        beat.status = stream_status;
        beat.end_of_stream = 1'b1;
        decoded_beats.insert(decoded_beats.size(), beat);
      end
      quad_fill = '0;
      sextet_acc = '0;
      pad_in_third = 1'b0;
      stream_status = ST_OK;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      quad_fill = '0;
      sextet_acc = '0;
      pad_in_third = 1'b0;
      stream_status = ST_OK;
      decoded_beats.delete();
    end else begin
      if (in_valid && !in_stall)
        decode_char(in_char_in, in_last_char);
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (decoded_beats.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected beat: expected none, actual byte %02h valid %0b",
                   $time, out_data_byte, out_byte_valid);
          $display("%0t   actual status %0d eos %0b",
                   $time, out_status, out_end_of_stream);
        end else begin
          want = decoded_beats.pop_front();
          if (out_data_byte !== want.data_byte) begin
            mismatch_count++;
            $display("%0t data_byte: expected %02h actual %02h",
                     $time, want.data_byte, out_data_byte);
          end
          if (out_byte_valid !== want.byte_valid) begin
            mismatch_count++;
            $display("%0t byte_valid: expected %0b actual %0b",
                     $time, want.byte_valid, out_byte_valid);
          end
          if (out_status !== want.status) begin
            mismatch_count++;
            $display("%0t status: expected %0d actual %0d", $time, want.status, out_status);
          end
          if (out_end_of_stream !== want.end_of_stream) begin
            mismatch_count++;
            $display("%0t end_of_stream: expected %0b actual %0b",
                     $time, want.end_of_stream, out_end_of_stream);
          end
        end
      end
    end
    beats_waiting <= decoded_beats.size();
  end

endmodule

// ===== test/tb_base64_stream_decoder_unit.sv =====
// stimulus, handshake idling and verdict for the base64 stream decoder
`timescale 1ns / 100ps

module tb_base64_stream_decoder_unit;
  import b64d_pkg::*;

  // coded (non-whitespace) characters to send after the directed streams
  localparam int RANDOM_CHARS = 80;
  // generous bound: a few hundred characters, each with a possible sender gap
  // and up to three beats each held by a receiver stall, many times over
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in   = '0;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic [1:0] out_status;
  logic       out_end_of_stream;

  int mismatch_count;
  int beats_waiting;
  int beats_checked;

  // idling knobs, percent chance per character / per cycle
  int gap_pct   = 15;
  int stall_pct = 20;

  int cycle_cnt     = 0;
  int coded_chars   = 0;
  int streams_sent  = 0;
  int clean_streams = 0;

  // characters of the stream being built; last_char goes on the final one
  logic [7:0] stream_q[$];

  base64_stream_decoder_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .in_last_char      (in_last_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_byte     (out_data_byte),
    .out_byte_valid    (out_byte_valid),
    .out_status        (out_status),
    .out_end_of_stream (out_end_of_stream)
  );

  b64d_stream_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .in_last_char      (in_last_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_byte     (out_data_byte),
    .out_byte_valid    (out_byte_valid),
    .out_status        (out_status),
    .out_end_of_stream (out_end_of_stream),
    .mismatch_count    (mismatch_count),
    .beats_waiting     (beats_waiting),
    .beats_checked     (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[base64_stream_decoder_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, none while stall_pct is zero
  always @(posedge clk) begin : rx_idle
    int burst;
    burst = 0;
    if (rst_n && stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
      burst = $urandom_range(1, 9);
      out_stall <= 1'b1;
      repeat (burst) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0:       return " ";
      1:       return "\t";
      2:       return "\n";
      default: return "\r";
    endcase
  endfunction

  // one character beat; returns at the edge that accepts it, valid left high
  task automatic send_char(input logic [7:0] ch, input logic last);
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_in   <= ch;
    in_last_char <= last;
    // in_stall read here is the value the block saw at this edge
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) begin
      send_char(stream_q[i], i == stream_q.size() - 1);
      if (!(stream_q[i] == " " || stream_q[i] == "\t" ||
            stream_q[i] == "\n" || stream_q[i] == "\r"))
        coded_chars++;
    end
    streams_sent++;
  endtask

  task automatic send_text(input string s);
    stream_q.delete();
    for (int i = 0; i < s.len(); i++)
      stream_q.insert(stream_q.size(), s[i]);
    send_stream();
  endtask

  // sender holds off until every predicted beat has been delivered
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_waiting != 0);
  endtask

  initial begin : stimulus
    int nbytes;
    int left;
    int mode;
    int pos;
    int start_chars;
    int done;
    bit paused;
    logic [23:0] word;
    logic [5:0] sx;
    logic [7:0] ch;

    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed streams
    send_text("////");            // all-ones bytes from the top of the alphabet
    send_text("Q Q=\t=");         // double pad with whitespace inside
    send_text("+/\n9\r=");        // plus, slash, digit, single pad
    stream_q = {8'hFF, "A"};      // code above 127 is a bad character
    send_stream();
    send_text("A=");              // pad in the second place
    send_text("Az=a");            // data after pad in the third place
    send_text("Zz");              // partial quad at the end
    send_text(" ");               // empty stream
    drain_results();

    start_chars = coded_chars;
    while (coded_chars - start_chars < RANDOM_CHARS) begin
      done = coded_chars - start_chars;
      // phases: moderate idling, none, heavy idling, none at the tail
      if (done < 20) begin
        gap_pct = 25;
        stall_pct = 30;
      end else if (done < 37) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (done < 63) begin
        gap_pct = 50;
        stall_pct = 60;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end

      // one full drain in the middle of the heavy phase
      if (!paused && done >= 50) begin
        paused = 1'b1;
        drain_results();
      end

      // well-formed encoding of 0..7 random bytes
      stream_q.delete();
      nbytes = $urandom_range(0, 7);
      for (int g = 0; g < nbytes; g += 3) begin
        left = (nbytes - g > 3) ? 3 : nbytes - g;
        word = {8'($urandom), 8'($urandom), 8'($urandom)};
        for (int k = 0; k < 4; k++) begin
          sx = word[23 - 6 * k -: 6];
          if (k > left) ch = "=";
          else if (sx < LOWER_BASE) ch = "A" + sx;
          else if (sx < DIGIT_BASE) ch = "a" + (sx - LOWER_BASE);
          else if (sx < PLUS_CODE) ch = "0" + (sx - DIGIT_BASE);
          else if (sx == PLUS_CODE) ch = "+";
          else ch = "/";
          if ($urandom_range(0, 5) == 0)
            stream_q.insert(stream_q.size(), rand_space());
          stream_q.insert(stream_q.size(), ch);
        end
      end
      if (stream_q.size() == 0 || $urandom_range(0, 7) == 0)
        stream_q.insert(stream_q.size(), rand_space());

      // most streams stay clean, the rest get broken or replaced by noise
      mode = $urandom_range(0, 9);
      if (mode == 7) begin
        pos = $urandom_range(0, stream_q.size() - 1);
        stream_q[pos] = $urandom_range(0, 1) ? 8'("=") : 8'($urandom_range(0, 255));
      end else if (mode == 8) begin
        stream_q.delete(stream_q.size() - 1);
        if (stream_q.size() == 0)
          stream_q.insert(0, "B");
      end else if (mode == 9) begin
        stream_q.delete();
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 3))
            0, 1:    stream_q.insert(stream_q.size(), 8'($urandom_range(0, 255)));
            2:       stream_q.insert(stream_q.size(), "=");
            default: stream_q.insert(stream_q.size(), "A" + 8'($urandom_range(0, 25)));
          endcase
        end
      end else begin
        clean_streams++;
      end
      send_stream();
    end

    drain_results();
    repeat (10) @(posedge clk);

    $display("covered %0d streams (%0d well-formed random), %0d coded characters,",
             streams_sent, clean_streams, coded_chars);
    $display("%0d result beats checked under sender gaps and receiver stalls",
             beats_checked);
    if (mismatch_count == 0 && beats_waiting == 0) begin
      $display("[base64_stream_decoder_unit] OK");
    end else begin
      $display("[base64_stream_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/b64d_pkg.sv
rtl/b64d_decode.sv
rtl/b64d_res_fifo.sv
rtl/base64_stream_decoder_unit.sv
test/b64d_stream_checker.sv
test/tb_base64_stream_decoder_unit.sv
